@@ hdl/fbik_pkg.sv @@
// ----------------------------------------------------------------------------
// fbik_pkg
// shared widths, stage types and the arctangent table for the five-bar leg
// inverse kinematics datapath
// ----------------------------------------------------------------------------
`default_nettype none

package fbik_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_N      = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    localparam int SQRT_N        = 34;
    localparam int NORM_N        = 6;
    localparam int LANE_DEPTH    = 4 + SQRT_N + 1 + NORM_N + CORDIC_N + 1;
    localparam int IDX_W         = 5;

    localparam logic [1:0] REG_TARGET_X = 2'd0;
    localparam logic [1:0] REG_BODY_LEN = 2'd1;
    localparam logic [1:0] REG_UPPER    = 2'd2;
    localparam logic [1:0] REG_LOWER    = 2'd3;

    localparam logic signed [15:0] TARGET_X_RST = 16'sd5000;
    localparam logic [14:0]        BODY_LEN_RST = 15'd10000;
    localparam logic [14:0]        UPPER_RST    = 15'd8000;
    localparam logic [14:0]        LOWER_RST    = 15'd12000;

    localparam logic signed [33:0] ANG_MAX = 34'sd18000;
    localparam logic signed [33:0] ANG_MIN = -34'sd18000;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507,
        32'd23437865, 32'd11730358, 32'd5866610, 32'd2933484,
        32'd1466764, 32'd733385, 32'd366693, 32'd183346,
        32'd91673, 32'd45837, 32'd22918, 32'd11459,
        32'd5730, 32'd2865, 32'd1432, 32'd716,
        32'd358, 32'd179, 32'd90, 32'd45,
        32'd22, 32'd11, 32'd6, 32'd3,
        32'd1, 32'd1, 32'd0, 32'd0
    };

    typedef struct packed {
        logic [36:0] rem;
        logic [33:0] q;
        logic [67:0] d;
        logic [34:0] b;
        logic [36:0] den;
        logic        ok;
    } sq_t;

    typedef struct packed {
        logic [44:0] x;
        logic [44:0] y;
        logic [31:0] z;
        logic        ok;
    } cd_t;

endpackage

`default_nettype wire

@@ hdl/five_bar_leg_inverse_kinematics.sv @@
// ----------------------------------------------------------------------------
// five_bar_leg_inverse_kinematics
// front and rear joint angles of two five-bar legs from their heights
// ----------------------------------------------------------------------------
// throughput: one request per cycle while the result is taken or the last stage
// is empty, set by the fully pipelined sqrt and cordic cell chains
// reset clears the valid chain and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module five_bar_leg_inverse_kinematics
    import fbik_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] height_left,
    input  wire logic signed [15:0] height_right,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      left_alpha,
    output logic signed [15:0]      left_beta,
    output logic signed [15:0]      right_alpha,
    output logic signed [15:0]      right_beta,
    output logic                    left_alpha_ok,
    output logic                    left_beta_ok,
    output logic                    right_alpha_ok,
    output logic                    right_beta_ok
);

    logic signed [15:0]    target_x_reg;
    logic [14:0]           body_len_reg;
    logic [14:0]           upper_reg;
    logic [14:0]           lower_reg;
    logic [LANE_DEPTH-1:0] vld_reg;
    logic                  en;
    logic signed [16:0]    xa;
    logic signed [16:0]    xb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg <= TARGET_X_RST;
            body_len_reg <= BODY_LEN_RST;
            upper_reg    <= UPPER_RST;
            lower_reg    <= LOWER_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET_X: target_x_reg <= cfg_data;
                REG_BODY_LEN: body_len_reg <= cfg_data[14:0];
                REG_UPPER:    upper_reg    <= cfg_data[14:0];
                REG_LOWER:    lower_reg    <= cfg_data[14:0];
                default:      ;
            endcase
        end
    end

    assign en       = ~vld_reg[LANE_DEPTH-1] | out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LANE_DEPTH-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[LANE_DEPTH-1];

    assign xa = 17'(target_x_reg);
    assign xb = 17'(target_x_reg) - $signed({2'b00, body_len_reg});

    fbik_lane u_left_alpha (
        .clk (clk), .en (en), .x (xa), .h (height_left),
        .l1 (upper_reg), .l2 (lower_reg),
        .angle (left_alpha), .ok (left_alpha_ok)
    );

    fbik_lane u_left_beta (
        .clk (clk), .en (en), .x (xb), .h (height_left),
        .l1 (upper_reg), .l2 (lower_reg),
        .angle (left_beta), .ok (left_beta_ok)
    );

    fbik_lane u_right_alpha (
        .clk (clk), .en (en), .x (xa), .h (height_right),
        .l1 (upper_reg), .l2 (lower_reg),
        .angle (right_alpha), .ok (right_alpha_ok)
    );

    fbik_lane u_right_beta (
        .clk (clk), .en (en), .x (xb), .h (height_right),
        .l1 (upper_reg), .l2 (lower_reg),
        .angle (right_beta), .ok (right_beta_ok)
    );

endmodule

`default_nettype wire

@@ hdl/fbik_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// fbik_sqrt_cell
// one digit of the integer square root, two radicand bits per cell
// ----------------------------------------------------------------------------
`default_nettype none

module fbik_sqrt_cell
    import fbik_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire sq_t  din,
    output sq_t       dout
);

    sq_t         cell_reg;
    sq_t         cell_next;
    logic [36:0] rem_sh;
    logic [36:0] trial;

    always_comb
    begin
        rem_sh    = {din.rem[34:0], din.d[67:66]};
        trial     = {1'b0, din.q, 2'b01};
        cell_next = din;
        cell_next.d = {din.d[65:0], 2'b00};
        if (rem_sh >= trial)
        begin
            cell_next.rem = rem_sh - trial;
            cell_next.q   = {din.q[32:0], 1'b1};
        end
        else
        begin
            cell_next.rem = rem_sh;
            cell_next.q   = {din.q[32:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

@@ hdl/fbik_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// fbik_cordic_cell
// one vectoring rotation, driving y toward zero and summing the angle
// ----------------------------------------------------------------------------
`default_nettype none

module fbik_cordic_cell
    import fbik_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [IDX_W-1:0] idx,
    input  wire cd_t              din,
    output cd_t                   dout
);

    cd_t                cell_reg;
    cd_t                cell_next;
    logic signed [44:0] dx;
    logic signed [44:0] dy;
    logic signed [31:0] ang;

    always_comb
    begin
        dx  = $signed(din.y) >>> idx;
        dy  = $signed(din.x) >>> idx;
        ang = $signed(ATAN_TAB[idx]);
        cell_next = din;
        if (!din.y[44])
        begin
            cell_next.x = 45'($signed(din.x) + dx);
            cell_next.y = 45'($signed(din.y) - dy);
            cell_next.z = 32'($signed(din.z) + ang);
        end
        else
        begin
            cell_next.x = 45'($signed(din.x) - dx);
            cell_next.y = 45'($signed(din.y) + dy);
            cell_next.z = 32'($signed(din.z) - ang);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

@@ hdl/fbik_lane.sv @@
// ----------------------------------------------------------------------------
// fbik_lane
// one joint angle: link equation terms, discriminant, square root chain,
// normalization, cordic chain and rounding
// ----------------------------------------------------------------------------
`default_nettype none

module fbik_lane
    import fbik_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [16:0] x,
    input  wire logic signed [15:0] h,
    input  wire logic [14:0]        l1,
    input  wire logic [14:0]        l2,
    output logic signed [15:0]      angle,
    output logic                    ok
);

    // term products
    logic signed [33:0] x_e, h_e, l1_e, l2_e;
    logic signed [33:0] xl_reg, hl_reg, xx_reg, hh_reg, l1sq_reg, l2sq_reg;

    assign x_e  = 34'(x);
    assign h_e  = 34'(h);
    assign l1_e = {19'd0, l1};
    assign l2_e = {19'd0, l2};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xl_reg   <= x_e * l1_e;
            hl_reg   <= h_e * l1_e;
            xx_reg   <= x_e * x_e;
            hh_reg   <= h_e * h_e;
            l1sq_reg <= l1_e * l1_e;
            l2sq_reg <= l2_e * l2_e;
        end
    end

    // a, b, c
    logic signed [34:0] a_reg, b_reg;
    logic signed [35:0] c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= {xl_reg, 1'b0};
            b_reg <= {hl_reg, 1'b0};
            c_reg <= 36'(xx_reg) + 36'(hh_reg) + 36'(l1sq_reg) - 36'(l2sq_reg);
        end
    end

    // squares
    logic [33:0]        am, bm, cm;
    logic [67:0]        asq_reg, bsq_reg, csq_reg;
    logic signed [34:0] b3_reg;
    logic signed [36:0] den3_reg;

    always_comb
    begin
        am = a_reg[34] ? 34'(-a_reg) : 34'(a_reg);
        bm = b_reg[34] ? 34'(-b_reg) : 34'(b_reg);
        cm = c_reg[35] ? 34'(-c_reg) : 34'(c_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            asq_reg  <= 68'(am) * 68'(am);
            bsq_reg  <= 68'(bm) * 68'(bm);
            csq_reg  <= 68'(cm) * 68'(cm);
            b3_reg   <= b_reg;
            den3_reg <= 37'(a_reg) + 37'(c_reg);
        end
    end

    // discriminant
    logic [68:0] sum;
    sq_t         sq_chain [SQRT_N+1];
    sq_t         sq0_reg;

    assign sum = 69'(asq_reg) + 69'(bsq_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq0_reg.rem <= '0;
            sq0_reg.q   <= '0;
            sq0_reg.d   <= 68'(sum - 69'(csq_reg));
            sq0_reg.b   <= b3_reg;
            sq0_reg.den <= den3_reg;
            sq0_reg.ok  <= (69'(csq_reg) <= sum) && (den3_reg != '0);
        end
    end

    assign sq_chain[0] = sq0_reg;

    genvar gi;
    generate
        for (gi = 0; gi < SQRT_N; gi++)
        begin : g_sqrt
            fbik_sqrt_cell u_cell (
                .clk  (clk),
                .en   (en),
                .din  (sq_chain[gi]),
                .dout (sq_chain[gi+1])
            );
        end
    endgenerate

    // fraction setup and normalization
    logic signed [36:0] num_raw;
    logic signed [36:0] den_raw;
    logic [40:0]        nd_reg  [NORM_N+1];
    logic signed [41:0] nn_reg  [NORM_N+1];
    logic               nok_reg [NORM_N+1];

    assign num_raw = $signed(sq_chain[SQRT_N].b) + $signed({3'b000, sq_chain[SQRT_N].q});
    assign den_raw = $signed(sq_chain[SQRT_N].den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (den_raw[36])
            begin
                nd_reg[0] <= 41'(-den_raw);
                nn_reg[0] <= 42'(-num_raw);
            end
            else
            begin
                nd_reg[0] <= 41'(den_raw);
                nn_reg[0] <= 42'(num_raw);
            end
            nok_reg[0] <= sq_chain[SQRT_N].ok;
        end
    end

    // larger magnitude ends in [2^40, 2^41)
    generate
        for (gi = 0; gi < NORM_N; gi++)
        begin : g_norm
            localparam int SH = 32 >> gi;
            logic [41:0] nmag;
            logic        do_sh;

            assign nmag  = nn_reg[gi][41] ? 42'(-nn_reg[gi]) : 42'(nn_reg[gi]);
            assign do_sh = (42'(nd_reg[gi]) < (42'd1 << (41 - SH)))
                        && (nmag < (42'd1 << (41 - SH)));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nd_reg[gi+1]  <= do_sh ? (nd_reg[gi] << SH) : nd_reg[gi];
                    nn_reg[gi+1]  <= do_sh ? (nn_reg[gi] <<< SH) : nn_reg[gi];
                    nok_reg[gi+1] <= nok_reg[gi];
                end
            end
        end
    endgenerate

    // cordic chain
    cd_t cd_chain [CORDIC_N+1];

    always_comb
    begin
        cd_chain[0].x  = {4'd0, nd_reg[NORM_N]};
        cd_chain[0].y  = 45'(nn_reg[NORM_N]);
        cd_chain[0].z  = '0;
        cd_chain[0].ok = nok_reg[NORM_N];
    end

    generate
        for (gi = 0; gi < CORDIC_N; gi++)
        begin : g_cordic
            fbik_cordic_cell u_cell (
                .clk  (clk),
                .en   (en),
                .idx  (IDX_W'(gi)),
                .din  (cd_chain[gi]),
                .dout (cd_chain[gi+1])
            );
        end
    endgenerate

    // round to 0.01 degree and clamp
    logic signed [33:0] zr;
    logic signed [15:0] ang_next;
    logic signed [15:0] angle_reg;
    logic               ok_reg;

    assign zr = ($signed({cd_chain[CORDIC_N].z[31], cd_chain[CORDIC_N].z, 1'b0})
               + 34'sd32768) >>> 16;

    always_comb
    begin
        if (!cd_chain[CORDIC_N].ok)
        begin
            ang_next = '0;
        end
        else if (zr > ANG_MAX)
        begin
            ang_next = 16'(ANG_MAX);
        end
        else if (zr < ANG_MIN)
        begin
            ang_next = 16'(ANG_MIN);
        end
        else
        begin
            ang_next = 16'(zr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= ang_next;
            ok_reg    <= cd_chain[CORDIC_N].ok;
        end
    end

    assign angle = angle_reg;
    assign ok    = ok_reg;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the five-bar leg inverse kinematics block: every
// accepted request is run through a bit-exact predictor (exact integer
// discriminant, bit-by-bit root, vectoring cordic) and each result is checked
// field by field in order, under random gaps on both handshakes and several
// register settings, the extremes among them
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import fbik_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic signed [15:0] angle [4];
        logic               ok    [4];
    } leg_angles_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] height_left = '0;
    logic signed [15:0] height_right = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] left_alpha, left_beta, right_alpha, right_beta;
    logic               left_alpha_ok, left_beta_ok, right_alpha_ok, right_beta_ok;

    logic signed [15:0] cur_target_x = TARGET_X_RST;
    logic [14:0]        cur_body     = BODY_LEN_RST;
    logic [14:0]        cur_upper    = UPPER_RST;
    logic [14:0]        cur_lower    = LOWER_RST;

    leg_angles_t expected_angles [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;

    five_bar_leg_inverse_kinematics uut (.*);

    always #1 clk = ~clk;

    function automatic longint root_floor(logic [127:0] d);
        logic [127:0] cand;
        longint       s;
        s = 0;
        for (int bitpos = 35; bitpos >= 0; bitpos--)
        begin
            cand = 128'(s | (64'd1 << bitpos));
            if (cand * cand <= d)
                s = longint'(cand);
        end
        return s;
    endfunction

    function automatic logic signed [15:0] joint_angle(input longint x, input longint h,
                                                        output logic ok);
        longint l1, l2, a, b, c, s, num, den, cx, cy, dx, dy, z, r;
        logic signed [127:0] wa, wb, wc, sum, csq;
        l1 = longint'(cur_upper);
        l2 = longint'(cur_lower);
        a = 2 * x * l1;
        b = 2 * h * l1;
        c = x * x + h * h + l1 * l1 - l2 * l2;
        wa = a;
        wb = b;
        wc = c;
        sum = wa * wa + wb * wb;
        csq = wc * wc;
        ok = 1'b0;
        if (csq > sum || a + c == 0)
            return '0;
        s = root_floor(128'(sum - csq));
        num = b + s;
        den = a + c;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        while (den < (64'sd1 <<< 40) && (num < 0 ? -num : num) < (64'sd1 <<< 40))
        begin
            den = den * 2;
            num = num * 2;
        end
        cx = den;
        cy = num;
        z = 0;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx += dx; cy -= dy; z += longint'(ATAN_TAB[i]);
            end
            else
            begin
                cx -= dx; cy += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        r = (2 * z + 32768) >>> 16;
        if (r > 18000) r = 18000;
        if (r < -18000) r = -18000;
        ok = 1'b1;
        return 16'(r);
    endfunction

    function automatic leg_angles_t predict_legs(logic signed [15:0] hl,
                                                 logic signed [15:0] hr);
        leg_angles_t e;
        longint      tx, xb;
        tx = longint'(cur_target_x);
        xb = tx - longint'(cur_body);
        e.angle[0] = joint_angle(tx, hl, e.ok[0]);
        e.angle[1] = joint_angle(xb, hl, e.ok[1]);
        e.angle[2] = joint_angle(tx, hr, e.ok[2]);
        e.angle[3] = joint_angle(xb, hr, e.ok[3]);
        return e;
    endfunction

    // result side stalls
    initial
    begin
        int gap;
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        leg_angles_t e;
        leg_angles_t got;
        if (out_valid && out_ready)
        begin
            got.angle = '{left_alpha, left_beta, right_alpha, right_beta};
            got.ok    = '{left_alpha_ok, left_beta_ok, right_alpha_ok, right_beta_ok};
            if (expected_angles.size() == 0)
            begin
                $display("%0t: unexpected result", $time);
                error_count++;
            end
            else
            begin
                e = expected_angles.pop_front();
                for (int k = 0; k < 4; k++)
                begin
                    if (got.angle[k] !== e.angle[k])
                    begin
                        $display("%0t: angle %0d expected %0d actual %0d",
                                 $time, k, e.angle[k], got.angle[k]);
                        error_count++;
                    end
                    if (got.ok[k] !== e.ok[k])
                    begin
                        $display("%0t: ok %0d expected %0b actual %0b",
                                 $time, k, e.ok[k], got.ok[k]);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_heights(logic signed [15:0] hl, logic signed [15:0] hr);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        height_left  <= hl;
        height_right <= hr;
        do @(posedge clk); while (!in_ready);
        expected_angles.push_back(predict_legs(hl, hr));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [15:0] value);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_TARGET_X: cur_target_x = value;
            REG_BODY_LEN: cur_body     = value[14:0];
            REG_UPPER:    cur_upper    = value[14:0];
            REG_LOWER:    cur_lower    = value[14:0];
            default:      ;
        endcase
    endtask

    task automatic test_directed;
        send_heights(16'sd0, 16'sd0);
        send_heights(16'sd12000, -16'sd12000);
        send_heights(16'sh7fff, 16'sh8000);
        send_heights(16'sd9000, 16'sd15000);
        send_heights(-16'sd5000, 16'sd3000);
        send_heights(16'sd18000, 16'sd1);
        // degenerate denominator: x = 0, h = 0, equal links
        set_reg(REG_TARGET_X, 16'd0);
        set_reg(REG_UPPER, 16'd100);
        set_reg(REG_LOWER, 16'd100);
        send_heights(16'sd0, 16'sd50);
        // extremes of the registers, high bit of the short ones set
        set_reg(REG_TARGET_X, 16'h8000);
        set_reg(REG_BODY_LEN, 16'hffff);
        set_reg(REG_UPPER, 16'hffff);
        set_reg(REG_LOWER, 16'hffff);
        send_heights(16'sh8000, 16'sh7fff);
        send_heights(16'sd0, -16'sd20000);
        set_reg(REG_TARGET_X, 16'h7fff);
        set_reg(REG_BODY_LEN, 16'd0);
        send_heights(16'sd100, 16'sh8000);
        set_reg(REG_UPPER, 16'd0);
        set_reg(REG_LOWER, 16'd0);
        send_heights(16'sd0, 16'sd7);
        set_reg(REG_TARGET_X, 16'd0);
        send_heights(16'sd0, 16'sd0);
        set_reg(REG_UPPER, 16'd8000);
        set_reg(REG_LOWER, 16'd12000);
        set_reg(REG_BODY_LEN, 16'd10000);
        send_heights(16'sd10000, -16'sd10000);
        send_heights(16'sd15000, 16'sd19900);
    endtask

    task automatic test_random;
        int reach;
        logic signed [15:0] hl, hr;
        for (int phase = 0; phase < 11; phase++)
        begin
            set_reg(REG_UPPER, 16'($urandom_range(1000, 14000)));
            set_reg(REG_LOWER, 16'($urandom_range(1000, 18000)));
            set_reg(REG_TARGET_X, 16'($signed($urandom_range(0, 24000)) - 12000));
            set_reg(REG_BODY_LEN, (phase == 3) ? 16'($urandom) :
                    16'($urandom_range(0, 20000)));
            no_gaps = (phase % 4 == 1);
            reach = int'(cur_upper) + int'(cur_lower);
            if (reach > 32767) reach = 32767;
            for (int n = 0; n < 50; n++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    hl = 16'($signed($urandom_range(0, 2 * reach)) - reach);
                    hr = 16'($signed($urandom_range(0, 2 * reach)) - reach);
                end
                else
                begin
                    hl = 16'($urandom);
                    hr = 16'($urandom);
                end
                send_heights(hl, hr);
                if (phase == 5 && n == 25)
                    drain();
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        drain();
        repeat (80) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
